@@ src/ptss_pkg.sv @@
package ptss_pkg;

    // Counter width of the packet counters.
    localparam int COUNT_WIDTH = 40;
    localparam int COUNT_OUT_W = 40;

    localparam int TS_W       = 64;
    localparam int FRAME_W    = 63;
    localparam int RATE_W     = 20;
    localparam int TB_W       = 31;
    localparam int KIND_W     = 3;
    localparam int CAND_W     = 52;
    localparam int SPP_W      = 12;
    localparam int CAND_PW    = COUNT_WIDTH + SPP_W;
    localparam int K_W        = TB_W + RATE_W;
    localparam int PROD_W     = TS_W + K_W + 1;
    localparam int MUL_STEPS  = TS_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [TS_W-1:0]    MISSING = {1'b1, {(TS_W-1){1'b0}}};
    localparam logic [FRAME_W-1:0] MAX63   = {FRAME_W{1'b1}};

    // Input command codes.
    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_REPORT  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TB_NUM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TB_DEN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODEC_KIND  = 2'd3;

    // Codec kinds.
    localparam logic [KIND_W-1:0] CODEC_AAC   = 3'd1;
    localparam logic [KIND_W-1:0] CODEC_MP3   = 3'd2;
    localparam logic [KIND_W-1:0] CODEC_MP2   = 3'd3;
    localparam logic [KIND_W-1:0] CODEC_WMAV2 = 3'd4;

    localparam logic [RATE_W-1:0] RATE_RESET     = 20'd48000;
    localparam logic [TB_W-1:0]   TB_NUM_RESET   = 31'd1;
    localparam logic [TB_W-1:0]   TB_DEN_RESET   = 31'd48000;
    localparam logic [RATE_W-1:0] RATE_MP3_SPLIT = 20'd32000;
    localparam logic [RATE_W-1:0] RATE_WMA_LOW   = 20'd16000;
    localparam logic [RATE_W-1:0] RATE_WMA_MID   = 20'd22050;

    localparam logic [SPP_W-1:0] SPP_512  = 12'd512;
    localparam logic [SPP_W-1:0] SPP_576  = 12'd576;
    localparam logic [SPP_W-1:0] SPP_1024 = 12'd1024;
    localparam logic [SPP_W-1:0] SPP_1152 = 12'd1152;
    localparam logic [SPP_W-1:0] SPP_2048 = 12'd2048;

    typedef enum logic [1:0] {
        SEL_WITHOUT_LAST,
        SEL_SPAN,
        SEL_SUM
    } conv_sel_t;

    typedef struct packed {
        logic      obs;
        logic      conv_start;
        conv_sel_t conv_sel;
        logic      capture;
        logic      load;
    } ptss_cmd_t;

    typedef struct packed {
        logic conv_done;
    } ptss_stat_t;

    typedef struct packed {
        logic                   selected_audio;
        logic signed [TS_W-1:0] pts;
        logic signed [TS_W-1:0] dts;
        logic signed [TS_W-1:0] duration;
    } ptss_pkt_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] packet_count;
        logic [COUNT_OUT_W-1:0] audio_packet_count;
        logic [COUNT_OUT_W-1:0] duration_packet_count;
        logic [COUNT_OUT_W-1:0] stamped_packet_count;
        logic                   pts_monotonic;
        logic signed [TS_W-1:0] first_pts;
        logic signed [TS_W-1:0] last_pts;
        logic signed [TS_W-1:0] last_end_pts;
        logic [FRAME_W-1:0]     duration_sum_frames;
        logic [FRAME_W-1:0]     span_frames;
        logic [FRAME_W-1:0]     span_without_last_frames;
        logic [CAND_W-1:0]      codec_frame_candidate;
    } ptss_report_t;

    // Samples per packet of the configured codec; zero for other codecs and for MP3 or WMAv2 at a zero rate.
    function automatic logic [SPP_W-1:0] samples_per_packet(
        input logic [KIND_W-1:0] kind,
        input logic [RATE_W-1:0] rate
    );
        logic [SPP_W-1:0] spp;
        spp = '0;
        case (kind)
            CODEC_AAC: spp = SPP_1024;
            CODEC_MP3:
            begin
                if (rate == '0)
                    spp = '0;
                else if (rate < RATE_MP3_SPLIT)
                    spp = SPP_576;
                else
                    spp = SPP_1152;
            end
            CODEC_MP2: spp = SPP_1152;
            CODEC_WMAV2:
            begin
                if (rate == '0)
                    spp = '0;
                else if (rate <= RATE_WMA_LOW)
                    spp = SPP_512;
                else if (rate <= RATE_WMA_MID)
                    spp = SPP_1024;
                else
                    spp = SPP_2048;
            end
            default: spp = '0;
        endcase
        return spp;
    endfunction

endpackage

@@ src/ptss_if.sv @@
interface ptss_in_if;
    import ptss_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic                   selected_audio;
    logic signed [TS_W-1:0] pts;
    logic signed [TS_W-1:0] dts;
    logic signed [TS_W-1:0] duration;
    modport source (output valid, cmd, selected_audio, pts, dts, duration, input ready);
    modport sink (input valid, cmd, selected_audio, pts, dts, duration, output ready);
endinterface

interface ptss_out_if;
    import ptss_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [COUNT_OUT_W-1:0] packet_count;
    logic [COUNT_OUT_W-1:0] audio_packet_count;
    logic [COUNT_OUT_W-1:0] duration_packet_count;
    logic [COUNT_OUT_W-1:0] stamped_packet_count;
    logic                   pts_monotonic;
    logic signed [TS_W-1:0] first_pts;
    logic signed [TS_W-1:0] last_pts;
    logic signed [TS_W-1:0] last_end_pts;
    logic [FRAME_W-1:0]     duration_sum_frames;
    logic [FRAME_W-1:0]     span_frames;
    logic [FRAME_W-1:0]     span_without_last_frames;
    logic [CAND_W-1:0]      codec_frame_candidate;
    modport source (output valid, packet_count, audio_packet_count, duration_packet_count,
        stamped_packet_count, pts_monotonic, first_pts, last_pts, last_end_pts,
        duration_sum_frames, span_frames, span_without_last_frames,
        codec_frame_candidate, input ready);
    modport sink (input valid, packet_count, audio_packet_count, duration_packet_count,
        stamped_packet_count, pts_monotonic, first_pts, last_pts, last_end_pts,
        duration_sum_frames, span_frames, span_without_last_frames,
        codec_frame_candidate, output ready);
endinterface

interface ptss_cfg_if;
    import ptss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/packet_timestamp_statistics_core.sv @@
// Packet timestamp statistics core.
// The pkt channel carries one word per demuxed packet (cmd observe) or a
// report request (cmd report). Observe words may follow each other in
// every cycle while no report is in progress. A report request reads
// the statistics and converts three time base quantities to sample frames on
// one shared conversion unit: a 64-step shift-add multiply followed by a
// 116-step restoring divide. pkt ready is low from acceptance of a report
// request until its word is loaded into the output register.
// The rpt channel carries one word per report. The word sits in an output
// register; if the receiver stalls, observe words keep being taken, and a
// further report request waits at its end until the register has been
// emptied. The cfg channel is always ready and writes sample rate, time base
// numerator, denominator and codec kind; write it only while no report is
// in progress.
// Reset clears all counters, marks all timestamps missing, sets the
// monotonic flag, and loads 48000 Hz, a 1/48000 time base and codec other.
module packet_timestamp_statistics_core (
    input  logic      clk,
    input  logic      rst_n,
    ptss_in_if.sink   pkt,
    ptss_out_if.source rpt,
    ptss_cfg_if.sink  cfg
);
    import ptss_pkg::*;

    ptss_cmd_t    cmd;
    ptss_stat_t   stat;
    ptss_pkt_t    pkt_word;
    ptss_report_t report;

    // Payload of the packet word as seen by the datapath.
    assign pkt_word.selected_audio = pkt.selected_audio;
    assign pkt_word.pts            = pkt.pts;
    assign pkt_word.dts            = pkt.dts;
    assign pkt_word.duration       = pkt.duration;

    ptss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt.valid),
        .pkt_cmd   (pkt.cmd),
        .pkt_ready (pkt.ready),
        .out_valid (rpt.valid),
        .out_ready (rpt.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptss_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .pkt    (pkt_word),
        .cfg    (cfg),
        .report (report)
    );

    // The report word goes out straight from the datapath's output register.
    assign rpt.packet_count             = report.packet_count;
    assign rpt.audio_packet_count       = report.audio_packet_count;
    assign rpt.duration_packet_count    = report.duration_packet_count;
    assign rpt.stamped_packet_count     = report.stamped_packet_count;
    assign rpt.pts_monotonic            = report.pts_monotonic;
    assign rpt.first_pts                = report.first_pts;
    assign rpt.last_pts                 = report.last_pts;
    assign rpt.last_end_pts             = report.last_end_pts;
    assign rpt.duration_sum_frames      = report.duration_sum_frames;
    assign rpt.span_frames              = report.span_frames;
    assign rpt.span_without_last_frames = report.span_without_last_frames;
    assign rpt.codec_frame_candidate    = report.codec_frame_candidate;

endmodule

@@ src/ptss_conv.sv @@
module ptss_conv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ptss_pkg::TS_W-1:0]      units,
    input  logic [ptss_pkg::TB_W-1:0]      num,
    input  logic [ptss_pkg::RATE_W-1:0]    rate,
    input  logic [ptss_pkg::TB_W-1:0]      den,
    output logic                           done,
    output logic [ptss_pkg::FRAME_W-1:0]   result
);
    import ptss_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_FIN} conv_state_t;

    conv_state_t        state_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [K_W-1:0]     k_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [TB_W-1:0]    rem_reg;
    logic               done_reg;
    logic [FRAME_W-1:0] result_reg;

    logic [K_W+1:0]     mul_sum;
    logic [TB_W:0]      div_cur;
    logic               div_ge;
    logic               rnd;
    logic [PROD_W-1:0]  q_final;

    // The upper part of p_reg accumulates the product while the multiplier
    // bits shift out at the bottom; the same register then holds the
    // dividend and collects quotient bits.
    always_comb
    begin
        mul_sum = {1'b0, p_reg[PROD_W-1:TS_W]} + (p_reg[0] ? {2'b00, k_reg} : '0);
        div_cur = {rem_reg, p_reg[PROD_W-1]};
        div_ge  = div_cur >= {1'b0, den};
        rnd     = {rem_reg, 1'b0} >= {1'b0, den};
        q_final = p_reg + PROD_W'(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == C_FIN);
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= K_W'(num) * K_W'(rate);
                        p_reg     <= {{(PROD_W-TS_W){1'b0}}, units};
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    p_reg <= {mul_sum[PROD_W-TS_W:0], p_reg[TS_W-1:1]};
                    if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= C_DIV;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                C_DIV:
                begin
                    rem_reg <= div_ge ? TB_W'(div_cur - {1'b0, den}) : div_cur[TB_W-1:0];
                    p_reg   <= {p_reg[PROD_W-2:0], div_ge};
                    if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= C_FIN;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                C_FIN:
                begin
                    if (den == '0 || q_final[PROD_W-1:FRAME_W] != '0)
                        result_reg <= '0;
                    else
                        result_reg <= q_final[FRAME_W-1:0];
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/ptss_datapath.sv @@
module ptss_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptss_pkg::ptss_cmd_t    cmd,
    output ptss_pkg::ptss_stat_t   stat,
    input  ptss_pkg::ptss_pkt_t    pkt,
    ptss_cfg_if.sink               cfg,
    output ptss_pkg::ptss_report_t report
);
    import ptss_pkg::*;

    logic [RATE_W-1:0]      rate_reg;
    logic [TB_W-1:0]        num_reg;
    logic [TB_W-1:0]        den_reg;
    logic [KIND_W-1:0]      kind_reg;

    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] audio_reg, audio_next;
    logic [COUNT_WIDTH-1:0] dur_cnt_reg, dur_cnt_next;
    logic [COUNT_WIDTH-1:0] stamped_reg, stamped_next;
    logic                   mono_reg, mono_next;
    logic [TS_W-1:0]        prev_reg, prev_next;
    logic [TS_W-1:0]        first_reg, first_next;
    logic [TS_W-1:0]        last_reg, last_next;
    logic [TS_W-1:0]        end_reg, end_next;
    logic [FRAME_W-1:0]     sum_reg, sum_next;

    logic [FRAME_W-1:0]     wl_res_reg;
    logic [FRAME_W-1:0]     span_res_reg;
    logic [FRAME_W-1:0]     sum_res_reg;
    ptss_report_t           report_reg;

    logic [TS_W-1:0]        stamp;
    logic                   has_dur;
    logic [TS_W-1:0]        dur_sum;
    logic [TS_W:0]          end_sum;
    logic                   cond_wl;
    logic                   cond_span;
    logic [TS_W-1:0]        units;
    logic                   conv_done;
    logic [FRAME_W-1:0]     conv_result;
    logic [SPP_W-1:0]       spp;
    logic [CAND_PW-1:0]     cand_prod;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    always_comb
    begin
        stamp   = (pkt.pts != MISSING) ? pkt.pts : pkt.dts;
        has_dur = pkt.duration > 0;
        dur_sum = {1'b0, sum_reg} + pkt.duration;
        end_sum = {1'b0, stamp ^ MISSING} + {1'b0, pkt.duration};

        total_next   = total_reg;
        audio_next   = audio_reg;
        dur_cnt_next = dur_cnt_reg;
        stamped_next = stamped_reg;
        mono_next    = mono_reg;
        prev_next    = prev_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        end_next     = end_reg;
        sum_next     = sum_reg;

        if (cmd.obs)
        begin
            total_next = sat_inc(total_reg);
            if (pkt.selected_audio)
            begin
                audio_next = sat_inc(audio_reg);
                if (has_dur)
                begin
                    dur_cnt_next = sat_inc(dur_cnt_reg);
                    sum_next     = dur_sum[TS_W-1] ? MAX63 : dur_sum[FRAME_W-1:0];
                end
                if (stamp != MISSING)
                begin
                    stamped_next = sat_inc(stamped_reg);
                    if (prev_reg != MISSING && $signed(stamp) < $signed(prev_reg))
                        mono_next = 1'b0;
                    prev_next = stamp;
                    if (first_reg == MISSING || $signed(stamp) < $signed(first_reg))
                        first_next = stamp;
                    if (last_reg == MISSING || !($signed(stamp) < $signed(last_reg)))
                    begin
                        last_next = stamp;
                        if (!has_dur)
                            end_next = stamp;
                        else if (end_sum[TS_W])
                            end_next = {1'b0, MAX63};
                        else
                            end_next = end_sum[TS_W-1:0] ^ MISSING;
                    end
                end
            end
        end
    end

    // Operand of the shared conversion unit. A span whose end is not above
    // its start converts zero; the unit then yields zero frames.
    always_comb
    begin
        cond_wl   = first_reg != MISSING && last_reg != MISSING
                    && $signed(first_reg) < $signed(last_reg);
        cond_span = first_reg != MISSING && end_reg != MISSING
                    && $signed(first_reg) < $signed(end_reg);
        case (cmd.conv_sel)
            SEL_WITHOUT_LAST: units = cond_wl ? last_reg - first_reg : '0;
            SEL_SPAN:         units = cond_span ? end_reg - first_reg : '0;
            SEL_SUM:          units = {1'b0, sum_reg};
            default:          units = '0;
        endcase
        spp       = samples_per_packet(kind_reg, rate_reg);
        cand_prod = audio_reg * spp;
    end

    ptss_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.conv_start),
        .units  (units),
        .num    (num_reg),
        .rate   (rate_reg),
        .den    (den_reg),
        .done   (conv_done),
        .result (conv_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= RATE_RESET;
            num_reg     <= TB_NUM_RESET;
            den_reg     <= TB_DEN_RESET;
            kind_reg    <= '0;
            total_reg   <= '0;
            audio_reg   <= '0;
            dur_cnt_reg <= '0;
            stamped_reg <= '0;
            mono_reg    <= 1'b1;
            prev_reg    <= MISSING;
            first_reg   <= MISSING;
            last_reg    <= MISSING;
            end_reg     <= MISSING;
            sum_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_SAMPLE_RATE: rate_reg <= cfg.data[RATE_W-1:0];
                    REG_TB_NUM:      num_reg  <= cfg.data[TB_W-1:0];
                    REG_TB_DEN:      den_reg  <= cfg.data[TB_W-1:0];
                    REG_CODEC_KIND:  kind_reg <= cfg.data[KIND_W-1:0];
                    default:         kind_reg <= kind_reg;
                endcase
            end
            total_reg   <= total_next;
            audio_reg   <= audio_next;
            dur_cnt_reg <= dur_cnt_next;
            stamped_reg <= stamped_next;
            mono_reg    <= mono_next;
            prev_reg    <= prev_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            end_reg     <= end_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            case (cmd.conv_sel)
                SEL_WITHOUT_LAST: wl_res_reg   <= conv_result;
                SEL_SPAN:         span_res_reg <= cond_span ? conv_result : wl_res_reg;
                SEL_SUM:          sum_res_reg  <= conv_result;
                default:          sum_res_reg  <= sum_res_reg;
            endcase
        end
        if (cmd.load)
        begin
            report_reg.packet_count             <= COUNT_OUT_W'(total_reg);
            report_reg.audio_packet_count       <= COUNT_OUT_W'(audio_reg);
            report_reg.duration_packet_count    <= COUNT_OUT_W'(dur_cnt_reg);
            report_reg.stamped_packet_count     <= COUNT_OUT_W'(stamped_reg);
            report_reg.pts_monotonic            <= mono_reg;
            report_reg.first_pts                <= first_reg;
            report_reg.last_pts                 <= last_reg;
            report_reg.last_end_pts             <= end_reg;
            report_reg.duration_sum_frames      <= sum_res_reg;
            report_reg.span_frames              <= span_res_reg;
            report_reg.span_without_last_frames <= wl_res_reg;
            report_reg.codec_frame_candidate    <=
                ((cand_prod >> FRAME_W) != '0) ? '0 : CAND_W'(cand_prod);
        end
    end

    assign cfg.ready      = 1'b1;
    assign stat.conv_done = conv_done;
    assign report         = report_reg;

`ifndef SYNTH
    a_first_not_above_last: assert property (@(posedge clk) disable iff (!rst_n)
        (first_reg != MISSING) |->
            (last_reg != MISSING && !($signed(last_reg) < $signed(first_reg))))
        else $error("smallest timestamp above the latest largest one");
`endif

endmodule

@@ src/ptss_ctrl.sv @@
module ptss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    input  logic                 pkt_cmd,
    output logic                 pkt_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ptss_pkg::ptss_stat_t stat,
    output ptss_pkg::ptss_cmd_t  cmd
);
    import ptss_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_LOAD} ctrl_state_t;

    ctrl_state_t state_reg;
    conv_sel_t   sel_reg;
    logic        ready_reg;
    logic        out_valid_reg;
    logic        accept;
    logic        load_ok;

    always_comb
    begin
        accept         = pkt_valid && ready_reg;
        load_ok        = !out_valid_reg || out_ready;
        cmd.obs        = accept && pkt_cmd == CMD_OBSERVE;
        cmd.conv_start = state_reg == S_START;
        cmd.conv_sel   = sel_reg;
        cmd.capture    = state_reg == S_WAIT && stat.conv_done;
        cmd.load       = state_reg == S_LOAD && load_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_WITHOUT_LAST;
            ready_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && pkt_cmd == CMD_REPORT)
                    begin
                        ready_reg <= 1'b0;
                        sel_reg   <= SEL_WITHOUT_LAST;
                        state_reg <= S_START;
                    end
                end
                S_START: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (stat.conv_done)
                    begin
                        case (sel_reg)
                            SEL_WITHOUT_LAST:
                            begin
                                sel_reg   <= SEL_SPAN;
                                state_reg <= S_START;
                            end
                            SEL_SPAN:
                            begin
                                sel_reg   <= SEL_SUM;
                                state_reg <= S_START;
                            end
                            default: state_reg <= S_LOAD;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (load_ok)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign pkt_ready = ready_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pkt_cmd == CMD_REPORT) |=> (state_reg == S_START))
        else $error("report request did not start the conversions");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ready_reg)
        else $error("input taken while a report is in progress");
    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
        else $error("report word shown without a load");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ptss_pkg::*;

    localparam int  LIMIT_CYCLES = 3_000_000;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 180;
    localparam logic [63:0] TS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TS_MIN = MISSING;

    logic clk;
    logic rst_n;

    ptss_in_if  pkt ();
    ptss_out_if rpt ();
    ptss_cfg_if cfg ();

    packet_timestamp_statistics_core u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pkt  (pkt),
        .rpt  (rpt),
        .cfg  (cfg)
    );

    // Shadow copy of the block's configuration and statistics.
    logic [RATE_W-1:0]   rate_q;
    logic [TB_W-1:0]     num_q;
    logic [TB_W-1:0]     den_q;
    logic [KIND_W-1:0]   kind_q;
    logic [39:0]         total_cnt;
    logic [39:0]         audio_cnt;
    logic [39:0]         dur_cnt;
    logic [39:0]         stamp_cnt;
    logic                mono_q;
    logic [63:0]         prev_ts;
    logic [63:0]         first_ts;
    logic [63:0]         last_ts;
    logic [63:0]         last_end_ts;
    logic [62:0]         unit_sum;

    ptss_report_t pending_reports[$];
    int           error_count;
    int           cycle_count;
    bit           no_idle;
    bit           wild;

    // Directed words. Only the first report, taken straight after reset, carries a
    // typed expectation; every other report is checked against the predictor.
    typedef struct {
        bit          cmd;
        bit          sel;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [63:0] dur;
        bit          typed;
    } stim_row_t;

    localparam ptss_report_t RESET_REPORT = '{
        packet_count: '0, audio_packet_count: '0, duration_packet_count: '0,
        stamped_packet_count: '0, pts_monotonic: 1'b1, first_pts: MISSING,
        last_pts: MISSING, last_end_pts: MISSING, duration_sum_frames: '0,
        span_frames: '0, span_without_last_frames: '0, codec_frame_candidate: '0};

    stim_row_t directed_rows[16];

    initial
    begin
        directed_rows = '{
            '{CMD_REPORT,  1'b0, 64'd0,   64'd0,   64'd0,        1'b1},
            '{CMD_OBSERVE, 1'b0, TS_MAX,  TS_MIN,  TS_MAX,       1'b0},
            '{CMD_OBSERVE, 1'b0, TS_MIN,  TS_MAX,  TS_MIN,       1'b0},
            '{CMD_OBSERVE, 1'b0, '1,      '1,      '1,           1'b0},
            '{CMD_OBSERVE, 1'b1, 64'd1000, 64'd0,  64'd24,       1'b0},
            '{CMD_OBSERVE, 1'b1, MISSING, 64'd1024, 64'd0,       1'b0},
            '{CMD_OBSERVE, 1'b1, MISSING, MISSING, 64'd7,        1'b0},
            '{CMD_OBSERVE, 1'b1, 64'd900, 64'd5,   -64'sd5,      1'b0},
            '{CMD_REPORT,  1'b0, 64'd0,   64'd0,   64'd0,        1'b0},
            '{CMD_OBSERVE, 1'b1, 64'd2000, 64'd0,  64'd1,        1'b0},
            '{CMD_OBSERVE, 1'b1, 64'd2000, 64'd0,  64'd48,       1'b0},
            '{CMD_OBSERVE, 1'b1, 64'd1500, 64'd0,  TS_MIN,       1'b0},
            '{CMD_OBSERVE, 1'b0, 64'd1,   64'd1,   64'd1,        1'b0},
            '{CMD_REPORT,  1'b1, '1,      '1,      '1,           1'b0},
            '{CMD_OBSERVE, 1'b1, 64'd2100, 64'd0,  64'd3,        1'b0},
            '{CMD_REPORT,  1'b0, 64'd0,   64'd0,   64'd0,        1'b0}
        };
    end

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Samples per packet for the shadow codec settings.
    function automatic logic [11:0] packet_samples();
        case (kind_q)
            CODEC_AAC:   return 12'd1024;
            CODEC_MP3:   return rate_q == 0 ? 12'd0 : (rate_q < 32000 ? 12'd576 : 12'd1152);
            CODEC_MP2:   return 12'd1152;
            CODEC_WMAV2:
            begin
                if (rate_q == 0)
                    return 12'd0;
                if (rate_q <= 16000)
                    return 12'd512;
                if (rate_q <= 22050)
                    return 12'd1024;
                return 12'd2048;
            end
            default:     return 12'd0;
        endcase
    endfunction

    // Time base units to sample frames, rounded half up; zero on overflow or when the units or a setting is zero.
    function automatic logic [62:0] units_to_frames(input logic [63:0] units);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        if (units == 0 || num_q == 0 || den_q == 0 || rate_q == 0)
            return '0;
        prod = 128'(units) * 128'(num_q) * 128'(rate_q);
        quo  = prod / 128'(den_q);
        rem  = prod % 128'(den_q);
        if (quo > 128'(TS_MAX))
            return '0;
        if (rem * 2 >= 128'(den_q))
            quo = quo + 1;
        if (quo > 128'(TS_MAX))
            return '0;
        return quo[62:0];
    endfunction

    function automatic logic [39:0] bump(input logic [39:0] c);
        return &c ? c : c + 1;
    endfunction

    // Updates the statistics for one accepted packet word.
    function automatic void track_packet(input bit sel, input logic [63:0] pts,
                                         input logic [63:0] dts, input logic [63:0] dur);
        logic        has_dur;
        logic [63:0] ts;
        logic [63:0] biased;
        has_dur   = dur != 0 && !dur[63];
        total_cnt = bump(total_cnt);
        if (!sel)
            return;
        audio_cnt = bump(audio_cnt);
        if (has_dur)
        begin
            dur_cnt  = bump(dur_cnt);
            unit_sum = (64'(unit_sum) > TS_MAX - dur) ? '1 : unit_sum + dur[62:0];
        end
        ts = pts != MISSING ? pts : dts;
        if (ts == MISSING)
            return;
        stamp_cnt = bump(stamp_cnt);
        if (prev_ts != MISSING && $signed(ts) < $signed(prev_ts))
            mono_q = 1'b0;
        prev_ts = ts;
        if (first_ts == MISSING || $signed(ts) < $signed(first_ts))
            first_ts = ts;
        if (last_ts == MISSING || !($signed(ts) < $signed(last_ts)))
        begin
            last_ts = ts;
            if (has_dur)
            begin
                biased      = ts ^ MISSING;
                last_end_ts = (biased > ~dur) ? TS_MAX : (biased + dur) ^ MISSING;
            end
            else
                last_end_ts = ts;
        end
    endfunction

    function automatic ptss_report_t build_report();
        ptss_report_t r;
        logic [62:0]  without_last;
        logic [11:0]  spp;
        without_last = '0;
        if (first_ts != MISSING && last_ts != MISSING && $signed(first_ts) < $signed(last_ts))
            without_last = units_to_frames(last_ts - first_ts);
        r.packet_count          = total_cnt;
        r.audio_packet_count    = audio_cnt;
        r.duration_packet_count = dur_cnt;
        r.stamped_packet_count  = stamp_cnt;
        r.pts_monotonic         = mono_q;
        r.first_pts             = first_ts;
        r.last_pts              = last_ts;
        r.last_end_pts          = last_end_ts;
        r.duration_sum_frames   = units_to_frames(64'(unit_sum));
        if (first_ts != MISSING && last_end_ts != MISSING
            && $signed(first_ts) < $signed(last_end_ts))
            r.span_frames = units_to_frames(last_end_ts - first_ts);
        else
            r.span_frames = without_last;
        r.span_without_last_frames = without_last;
        spp = packet_samples();
        // With 40-bit counters the product always fits in 52 bits.
        r.codec_frame_candidate = 52'(audio_cnt) * 52'(spp);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    // Report word checker: every accepted word pops the oldest expectation.
    always @(posedge clk)
    begin
        ptss_report_t want;
        if (rst_n && rpt.valid && rpt.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("unexpected report word at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (rpt.packet_count !== want.packet_count)
                    report_mismatch("packet_count", rpt.packet_count, want.packet_count);
                if (rpt.audio_packet_count !== want.audio_packet_count)
                    report_mismatch("audio_packet_count", rpt.audio_packet_count,
                                    want.audio_packet_count);
                if (rpt.duration_packet_count !== want.duration_packet_count)
                    report_mismatch("duration_packet_count", rpt.duration_packet_count,
                                    want.duration_packet_count);
                if (rpt.stamped_packet_count !== want.stamped_packet_count)
                    report_mismatch("stamped_packet_count", rpt.stamped_packet_count,
                                    want.stamped_packet_count);
                if (rpt.pts_monotonic !== want.pts_monotonic)
                    report_mismatch("pts_monotonic", rpt.pts_monotonic, want.pts_monotonic);
                if (rpt.first_pts !== want.first_pts)
                    report_mismatch("first_pts", rpt.first_pts, want.first_pts);
                if (rpt.last_pts !== want.last_pts)
                    report_mismatch("last_pts", rpt.last_pts, want.last_pts);
                if (rpt.last_end_pts !== want.last_end_pts)
                    report_mismatch("last_end_pts", rpt.last_end_pts, want.last_end_pts);
                if (rpt.duration_sum_frames !== want.duration_sum_frames)
                    report_mismatch("duration_sum_frames", rpt.duration_sum_frames,
                                    want.duration_sum_frames);
                if (rpt.span_frames !== want.span_frames)
                    report_mismatch("span_frames", rpt.span_frames, want.span_frames);
                if (rpt.span_without_last_frames !== want.span_without_last_frames)
                    report_mismatch("span_without_last_frames", rpt.span_without_last_frames,
                                    want.span_without_last_frames);
                if (rpt.codec_frame_candidate !== want.codec_frame_candidate)
                    report_mismatch("codec_frame_candidate", rpt.codec_frame_candidate,
                                    want.codec_frame_candidate);
            end
        end
    end

    // The receiver stalls at random, except during the stretch without idling.
    always @(negedge clk)
    begin
        rpt.ready <= no_idle || ($urandom_range(99) >= 19);
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    // Sends one word on pkt. The call starts right after the previous acceptance
    // edge, so valid changes at most once per falling edge.
    task automatic send_word(input bit cmd, input bit sel, input logic [63:0] pts,
                             input logic [63:0] dts, input logic [63:0] dur,
                             input bit typed);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 19)
        begin
            pkt.valid = 1'b0;
            @(negedge clk);
        end
        pkt.valid          = 1'b1;
        pkt.cmd            = cmd;
        pkt.selected_audio = sel;
        pkt.pts            = pts;
        pkt.dts            = dts;
        pkt.duration       = dur;
        do
            @(posedge clk);
        while (!pkt.ready);
        if (cmd == CMD_REPORT)
            pending_reports.push_back(typed ? RESET_REPORT : build_report());
        else
            track_packet(sel, pts, dts, dur);
    endtask

    // Lowers valid, waits until every report has arrived and the last packet
    // word has settled, so that configuration can be written safely.
    task automatic wait_idle();
        @(negedge clk);
        pkt.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_SAMPLE_RATE: rate_q = value[RATE_W-1:0];
            REG_TB_NUM:      num_q  = value;
            REG_TB_DEN:      den_q  = value;
            REG_CODEC_KIND:  kind_q = value[KIND_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Rates around the codec thresholds matter most for the candidate.
    function automatic logic [30:0] pick_rate();
        case ($urandom_range(9))
            0: return 31'd16000;
            1: return 31'd16001;
            2: return 31'd22050;
            3: return 31'd22051;
            4: return 31'd31999;
            5: return 31'd32000;
            6: return 31'd44100;
            7: return 31'($urandom);
            default: return 31'(48000);
        endcase
    endfunction

    // Picks the configuration of one phase; the first phases take the extremes.
    task automatic configure_phase(input int phase);
        logic [30:0] rate;
        logic [30:0] num;
        logic [30:0] den;
        case (phase)
            0:
            begin
                rate = 31'h000F_FFFF;
                num  = 31'h7FFF_FFFF;
                den  = 31'd1;
            end
            1:
            begin
                rate = '0;
                num  = '0;
                den  = '0;
            end
            2:
            begin
                rate = 31'd768000;
                num  = 31'd1;
                den  = 31'h7FFF_FFFF;
            end
            default:
            begin
                rate = pick_rate();
                num  = $urandom_range(3) == 0 ? 31'd1 : 31'($urandom_range(1000, 1));
                den  = 31'($urandom_range(200000, 1));
            end
        endcase
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_TB_NUM, num);
        write_reg(REG_TB_DEN, den);
        write_reg(REG_CODEC_KIND, 31'(phase % 8));
    endtask

    initial
    begin
        logic [63:0] cursor;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [63:0] dur;
        bit          sel;
        bit          cmd;
        int          pick;

        rst_n              = 1'b0;
        pkt.valid          = 1'b0;
        pkt.cmd            = CMD_OBSERVE;
        pkt.selected_audio = 1'b0;
        pkt.pts            = '0;
        pkt.dts            = '0;
        pkt.duration       = '0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_SAMPLE_RATE;
        cfg.data           = '0;
        rpt.ready          = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        no_idle            = 1'b0;
        wild               = 1'b0;

        // Shadow state as after reset.
        rate_q      = 20'd48000;
        num_q       = 31'd1;
        den_q       = 31'd48000;
        kind_q      = '0;
        total_cnt   = '0;
        audio_cnt   = '0;
        dur_cnt     = '0;
        stamp_cnt   = '0;
        mono_q      = 1'b1;
        prev_ts     = MISSING;
        first_ts    = MISSING;
        last_ts     = MISSING;
        last_end_ts = MISSING;
        unit_sum    = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].sel, directed_rows[i].pts,
                      directed_rows[i].dts, directed_rows[i].dur, directed_rows[i].typed);

        cursor = 64'd2200;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Each phase boundary also makes the sender hold off until every
            // report has come back.
            wait_idle();
            configure_phase(phase);
            no_idle = (phase == 3);
            wild    = (phase == PHASES - 1);

            // The last phase opens with the saturation cases, since these leave
            // the statistics pinned for the rest of the run.
            if (wild)
            begin
                send_word(CMD_OBSERVE, 1'b1, TS_MAX - 3, 64'd0, 64'd100, 1'b0);
                send_word(CMD_REPORT, 1'b0, '0, '0, '0, 1'b0);
                send_word(CMD_OBSERVE, 1'b1, TS_MIN + 1, TS_MIN, TS_MAX, 1'b0);
                send_word(CMD_OBSERVE, 1'b1, 64'd0, TS_MAX, TS_MAX, 1'b0);
                send_word(CMD_REPORT, 1'b0, '0, '0, '0, 1'b0);
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                cmd  = ($urandom_range(14) == 0) ? CMD_REPORT : CMD_OBSERVE;
                sel  = $urandom_range(9) != 0;
                pick = $urandom_range(99);
                // Mostly a well-formed stream: rising timestamps, small durations.
                cursor = cursor + 64'($urandom_range(2000));
                pts    = cursor;
                dts    = cursor - 64'($urandom_range(50));
                if (pick < 5)
                    pts = MISSING;
                else if (pick < 8)
                begin
                    pts = MISSING;
                    dts = MISSING;
                end
                else if (pick < 13)
                    pts = cursor - 64'($urandom_range(5000));
                else if (wild && pick < 40)
                begin
                    pts = rand64();
                    dts = rand64();
                end
                pick = $urandom_range(99);
                if (pick < 8)
                    dur = '0;
                else if (pick < 14)
                    dur = -64'($urandom_range(1000, 1));
                else if (wild && pick < 40)
                    dur = rand64();
                else
                    dur = 64'($urandom_range(4800, 1));
                send_word(cmd, sel, pts, dts, dur, 1'b0);
            end
            send_word(CMD_REPORT, 1'b0, '0, '0, '0, 1'b0);
        end

        @(negedge clk);
        pkt.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ptss_pkg.sv
src/ptss_if.sv
src/ptss_conv.sv
src/ptss_datapath.sv
src/ptss_ctrl.sv
src/packet_timestamp_statistics_core.sv
tb/tb.sv
